// ===== hdl/ssdck_pkg.sv =====
// shared types and constants for the span sprite decoder with colour key
// no dependencies; used by span_sprite_decoder_color_key
`default_nettype none

package ssdck_pkg;

    // width of the coordinate words and the frame size registers
    localparam int COORD_BITS = 16;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_KEY_RED       = 3'd0;
    localparam logic [2:0] REG_KEY_GREEN     = 3'd1;
    localparam logic [2:0] REG_KEY_BLUE      = 3'd2;
    localparam logic [2:0] REG_KEY_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd4;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd5;

    // configuration reset values
    localparam logic [7:0]  KEY_RED_RST       = 8'd255;
    localparam logic [7:0]  KEY_GREEN_RST     = 8'd82;
    localparam logic [7:0]  KEY_BLUE_RST      = 8'd255;
    localparam logic [7:0]  KEY_THRESHOLD_RST = 8'd20;

    // steps of the multiply sequence
    localparam logic [3:0] MSTEP_RED   = 4'd0;
    localparam logic [3:0] MSTEP_GREEN = 4'd1;
    localparam logic [3:0] MSTEP_BLUE  = 4'd2;
    localparam logic [3:0] MSTEP_TSQ   = 4'd3;
    localparam logic [3:0] MSTEP_SCALE = 4'd4;

    // last iteration of the square root and of the divide
    localparam logic [3:0] SQRT_LAST = 4'd15;
    localparam logic [3:0] DIV_LAST  = 4'd7;

    // 255 squared, scales d2 so that the root carries the 255 factor
    localparam logic [15:0] SCALE_255SQ = 16'd65025;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

    // stream parser phase
    typedef enum logic [4:0] {
        PH_COUNT = 5'b00001,
        PH_X     = 5'b00010,
        PH_Y     = 5'b00100,
        PH_PIX   = 5'b01000,
        PH_DRAIN = 5'b10000
    } phase_t;

    // arithmetic sequencer state
    typedef enum logic [4:0] {
        SEQ_IDLE = 5'b00001,
        SEQ_MUL  = 5'b00010,
        SEQ_SQRT = 5'b00100,
        SEQ_DIV  = 5'b01000,
        SEQ_OUT  = 5'b10000
    } seq_t;

    // 5-bit to 8-bit colour expansion, floor(c * 255 / 31)
    localparam logic [7:0] WIDEN5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

endpackage

`default_nettype wire

// ===== hdl/span_sprite_decoder_color_key.sv =====
// span sprite decoder: parses count/x/y/pixel words and emits keyed pixel writes
// depends on ssdck_pkg (types, register indexes, expansion table)
// a frame end with no pixel reaches the output register in the cycle after its word;
// a pixel write passes multiply, root, divide and output steps, an opaque one only
// multiply and output, on the shared 16x16 multiplier and 18-bit subtractor; one word
// per cycle while no pixel is pending and the output is not stalled; sync active-low reset
`default_nettype none

module span_sprite_decoder_color_key (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_stream_word,
    input  wire logic        s_end_of_data,
    // pixel write results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_write_enable,
    output logic [15:0]      m_pix_x,
    output logic [15:0]      m_pix_y,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    output logic [7:0]       m_alpha,
    output logic             m_frame_done,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CB = ssdck_pkg::COORD_BITS;

    // configuration registers
    logic [7:0]  key_red_reg, key_red_next;
    logic [7:0]  key_green_reg, key_green_next;
    logic [7:0]  key_blue_reg, key_blue_next;
    logic [7:0]  key_threshold_reg, key_threshold_next;
    logic [15:0] frame_width_reg, frame_width_next;
    logic [15:0] frame_height_reg, frame_height_next;

    // parser state
    ssdck_pkg::phase_t phase_reg, phase_next;
    logic [15:0]   span_remaining_reg, span_remaining_next;
    logic [CB-1:0] span_x_reg, span_x_next;
    logic [CB-1:0] span_y_reg, span_y_next;
    logic [15:0]   span_offset_reg, span_offset_next;
    logic          skip_span_reg, skip_span_next;

    // sequencer and its datapath
    ssdck_pkg::seq_t seq_reg, seq_next;
    logic [3:0]  step_reg, step_next;
    logic [17:0] d2_reg, d2_next;
    logic [15:0] tsq_reg, tsq_next;
    logic [31:0] rad_reg, rad_next;
    logic [17:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;

    // pending pixel
    logic [15:0] px_reg, px_next;
    logic [15:0] py_reg, py_next;
    logic [7:0]  r_reg, r_next;
    logic [7:0]  g_reg, g_next;
    logic [7:0]  b_reg, b_next;
    logic        pend_done_reg, pend_done_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic        m_we_reg, m_we_next;
    logic [15:0] m_x_reg, m_x_next;
    logic [15:0] m_y_reg, m_y_next;
    logic [7:0]  m_r_reg, m_r_next;
    logic [7:0]  m_g_reg, m_g_next;
    logic [7:0]  m_b_reg, m_b_next;
    logic [7:0]  m_a_reg, m_a_next;
    logic        m_done_reg, m_done_next;

    // combinational helpers
    logic          accept;
    logic          cfg_write;
    logic [CB-1:0] word_m;
    logic [CB-1:0] fw_m;
    logic [CB-1:0] fh_m;
    logic [16:0]   pix_sum;
    logic          pix_write;
    logic [7:0]    comp_val;
    logic [7:0]    comp_key;
    logic [7:0]    comp_diff;
    logic [15:0]   mul_a;
    logic [15:0]   mul_b;
    logic [31:0]   mul_p;
    logic [17:0]   sub_a;
    logic [17:0]   sub_b;
    logic [18:0]   sub_full;
    logic          sub_ok;
    logic [15:0]   root_new;

    // handshake outputs
    assign pready  = 1'b1;
    assign s_ready = (seq_reg == ssdck_pkg::SEQ_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite;

    assign m_valid        = m_valid_reg;
    assign m_write_enable = m_we_reg;
    assign m_pix_x        = m_x_reg;
    assign m_pix_y        = m_y_reg;
    assign m_red          = m_r_reg;
    assign m_green        = m_g_reg;
    assign m_blue         = m_b_reg;
    assign m_alpha        = m_a_reg;
    assign m_frame_done   = m_done_reg;

    // register read back
    always_comb begin
        unique case (paddr[4:2])
            ssdck_pkg::REG_KEY_RED:       prdata = {24'd0, key_red_reg};
            ssdck_pkg::REG_KEY_GREEN:     prdata = {24'd0, key_green_reg};
            ssdck_pkg::REG_KEY_BLUE:      prdata = {24'd0, key_blue_reg};
            ssdck_pkg::REG_KEY_THRESHOLD: prdata = {24'd0, key_threshold_reg};
            ssdck_pkg::REG_FRAME_WIDTH:   prdata = {16'd0, frame_width_reg};
            ssdck_pkg::REG_FRAME_HEIGHT:  prdata = {16'd0, frame_height_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // coordinate masking and clip test
    assign word_m    = s_stream_word[CB-1:0];
    assign fw_m      = frame_width_reg[CB-1:0];
    assign fh_m      = frame_height_reg[CB-1:0];
    assign pix_sum   = {1'b0, 16'(span_x_reg)} + {1'b0, span_offset_reg};
    assign pix_write = !skip_span_reg && (pix_sum < {1'b0, 16'(fw_m)});

    // colour component picked for the current squaring step
    always_comb begin
        unique case (step_reg)
            ssdck_pkg::MSTEP_GREEN: begin
                comp_val = g_reg;
                comp_key = key_green_reg;
            end
            ssdck_pkg::MSTEP_BLUE: begin
                comp_val = b_reg;
                comp_key = key_blue_reg;
            end
            default: begin
                comp_val = r_reg;
                comp_key = key_red_reg;
            end
        endcase
    end
    assign comp_diff = (comp_val > comp_key) ? (comp_val - comp_key) : (comp_key - comp_val);

    // shared multiplier operands
    always_comb begin
        unique case (step_reg)
            ssdck_pkg::MSTEP_TSQ: begin
                mul_a = {8'd0, key_threshold_reg};
                mul_b = {8'd0, key_threshold_reg};
            end
            ssdck_pkg::MSTEP_SCALE: begin
                mul_a = ssdck_pkg::SCALE_255SQ;
                mul_b = d2_reg[15:0];
            end
            default: begin
                mul_a = {8'd0, comp_diff};
                mul_b = {8'd0, comp_diff};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // shared compare and subtract unit for root and divide iterations
    always_comb begin
        if (seq_reg == ssdck_pkg::SEQ_DIV) begin
            sub_a = {9'd0, rem_reg[7:0], root_reg[7]};
            sub_b = {10'd0, key_threshold_reg};
        end else begin
            sub_a = {rem_reg[15:0], rad_reg[31:30]};
            sub_b = {root_reg, 2'b01};
        end
    end
    assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ok   = !sub_full[18];
    assign root_new = {root_reg[14:0], sub_ok};

    // next-state logic
    always_comb begin
        logic term;
        logic drain;
        logic start_calc;
        logic done_now;

        term       = 1'b0;
        drain      = 1'b0;
        start_calc = 1'b0;
        done_now   = 1'b0;

        key_red_next       = key_red_reg;
        key_green_next     = key_green_reg;
        key_blue_next      = key_blue_reg;
        key_threshold_next = key_threshold_reg;
        frame_width_next   = frame_width_reg;
        frame_height_next  = frame_height_reg;

        phase_next          = phase_reg;
        span_remaining_next = span_remaining_reg;
        span_x_next         = span_x_reg;
        span_y_next         = span_y_reg;
        span_offset_next    = span_offset_reg;
        skip_span_next      = skip_span_reg;

        seq_next  = seq_reg;
        step_next = step_reg;
        d2_next   = d2_reg;
        tsq_next  = tsq_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;

        px_next        = px_reg;
        py_next        = py_reg;
        r_next         = r_reg;
        g_next         = g_reg;
        b_next         = b_reg;
        pend_done_next = pend_done_reg;

        m_valid_next = m_valid_reg;
        m_we_next    = m_we_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_r_next     = m_r_reg;
        m_g_next     = m_g_reg;
        m_b_next     = m_b_reg;
        m_a_next     = m_a_reg;
        m_done_next  = m_done_reg;

        // configuration writes
        if (cfg_write) begin
            unique case (paddr[4:2])
                ssdck_pkg::REG_KEY_RED:       key_red_next       = pwdata[7:0];
                ssdck_pkg::REG_KEY_GREEN:     key_green_next     = pwdata[7:0];
                ssdck_pkg::REG_KEY_BLUE:      key_blue_next      = pwdata[7:0];
                ssdck_pkg::REG_KEY_THRESHOLD: key_threshold_next = pwdata[7:0];
                ssdck_pkg::REG_FRAME_WIDTH:   frame_width_next   = pwdata[15:0];
                ssdck_pkg::REG_FRAME_HEIGHT:  frame_height_next  = pwdata[15:0];
                default: ;
            endcase
        end

        // output register drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // stream parser
        if (accept) begin
            unique case (phase_reg)
                ssdck_pkg::PH_X: begin
                    span_x_next = word_m;
                    phase_next  = ssdck_pkg::PH_Y;
                end
                ssdck_pkg::PH_Y: begin
                    span_y_next      = word_m;
                    span_offset_next = 16'd0;
                    skip_span_next   = (span_x_reg >= fw_m) || (word_m >= fh_m);
                    phase_next       = ssdck_pkg::PH_PIX;
                end
                ssdck_pkg::PH_PIX: begin
                    start_calc          = pix_write;
                    span_offset_next    = span_offset_reg + 16'd1;
                    span_remaining_next = span_remaining_reg - 16'd1;
                    if (span_remaining_reg == 16'd1) begin
                        phase_next = ssdck_pkg::PH_COUNT;
                    end
                end
                ssdck_pkg::PH_DRAIN: begin
                    drain = 1'b1;
                    if (s_end_of_data) begin
                        phase_next = ssdck_pkg::PH_COUNT;
                    end
                end
                default: begin
                    // count word; zero ends the frame
                    if (s_stream_word == 16'd0) begin
                        term       = 1'b1;
                        phase_next = s_end_of_data ? ssdck_pkg::PH_COUNT
                                                   : ssdck_pkg::PH_DRAIN;
                    end else begin
                        span_remaining_next = s_stream_word;
                        phase_next          = ssdck_pkg::PH_X;
                    end
                end
            endcase

            done_now = !drain && (term || s_end_of_data);
            if (!drain && s_end_of_data) begin
                phase_next = ssdck_pkg::PH_COUNT;
            end

            if (start_calc) begin
                // pixel write: hand the colour to the sequencer
                seq_next       = ssdck_pkg::SEQ_MUL;
                step_next      = ssdck_pkg::MSTEP_RED;
                px_next        = pix_sum[15:0];
                py_next        = 16'(span_y_reg);
                r_next         = ssdck_pkg::WIDEN5[s_stream_word[14:10]];
                g_next         = ssdck_pkg::WIDEN5[s_stream_word[9:5]];
                b_next         = ssdck_pkg::WIDEN5[s_stream_word[4:0]];
                pend_done_next = done_now;
            end else if (done_now) begin
                // frame end with no pixel
                m_valid_next = 1'b1;
                m_we_next    = 1'b0;
                m_x_next     = 16'd0;
                m_y_next     = 16'd0;
                m_r_next     = 8'd0;
                m_g_next     = 8'd0;
                m_b_next     = 8'd0;
                m_a_next     = 8'd0;
                m_done_next  = 1'b1;
            end
        end

        // alpha sequencer
        unique case (seq_reg)
            ssdck_pkg::SEQ_MUL: begin
                step_next = step_reg + 4'd1;
                unique case (step_reg)
                    ssdck_pkg::MSTEP_RED:   d2_next = mul_p[17:0];
                    ssdck_pkg::MSTEP_GREEN: d2_next = d2_reg + mul_p[17:0];
                    ssdck_pkg::MSTEP_BLUE:  d2_next = d2_reg + mul_p[17:0];
                    ssdck_pkg::MSTEP_TSQ:   tsq_next = mul_p[15:0];
                    default: begin
                        // fade only inside the threshold radius
                        if (key_threshold_reg == 8'd0 || d2_reg >= {2'b00, tsq_reg}) begin
                            root_next = {8'd0, ssdck_pkg::ALPHA_OPAQUE};
                            seq_next  = ssdck_pkg::SEQ_OUT;
                        end else begin
                            rad_next  = mul_p;
                            rem_next  = 18'd0;
                            root_next = 16'd0;
                            step_next = 4'd0;
                            seq_next  = ssdck_pkg::SEQ_SQRT;
                        end
                    end
                endcase
            end
            ssdck_pkg::SEQ_SQRT: begin
                // one root bit per cycle
                rad_next  = {rad_reg[29:0], 2'b00};
                rem_next  = sub_ok ? sub_full[17:0] : sub_a;
                root_next = root_new;
                step_next = step_reg + 4'd1;
                if (step_reg == ssdck_pkg::SQRT_LAST) begin
                    // divide starts with the top byte as partial remainder
                    rem_next  = {10'd0, root_new[15:8]};
                    step_next = 4'd0;
                    seq_next  = ssdck_pkg::SEQ_DIV;
                end
            end
            ssdck_pkg::SEQ_DIV: begin
                // one quotient bit per cycle, quotient shifts into the low byte
                rem_next       = sub_ok ? sub_full[17:0] : sub_a;
                root_next[7:0] = {root_reg[6:0], sub_ok};
                step_next      = step_reg + 4'd1;
                if (step_reg == ssdck_pkg::DIV_LAST) begin
                    seq_next = ssdck_pkg::SEQ_OUT;
                end
            end
            ssdck_pkg::SEQ_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_we_next    = 1'b1;
                    m_x_next     = px_reg;
                    m_y_next     = py_reg;
                    m_r_next     = r_reg;
                    m_g_next     = g_reg;
                    m_b_next     = b_reg;
                    m_a_next     = root_reg[7:0];
                    m_done_next  = pend_done_reg;
                    seq_next     = ssdck_pkg::SEQ_IDLE;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_red_reg        <= ssdck_pkg::KEY_RED_RST;
            key_green_reg      <= ssdck_pkg::KEY_GREEN_RST;
            key_blue_reg       <= ssdck_pkg::KEY_BLUE_RST;
            key_threshold_reg  <= ssdck_pkg::KEY_THRESHOLD_RST;
            frame_width_reg    <= 16'd0;
            frame_height_reg   <= 16'd0;
            phase_reg          <= ssdck_pkg::PH_COUNT;
            span_remaining_reg <= 16'd0;
            span_x_reg         <= '0;
            span_y_reg         <= '0;
            span_offset_reg    <= 16'd0;
            skip_span_reg      <= 1'b0;
            seq_reg            <= ssdck_pkg::SEQ_IDLE;
            step_reg           <= 4'd0;
            m_valid_reg        <= 1'b0;
        end else begin
            key_red_reg        <= key_red_next;
            key_green_reg      <= key_green_next;
            key_blue_reg       <= key_blue_next;
            key_threshold_reg  <= key_threshold_next;
            frame_width_reg    <= frame_width_next;
            frame_height_reg   <= frame_height_next;
            phase_reg          <= phase_next;
            span_remaining_reg <= span_remaining_next;
            span_x_reg         <= span_x_next;
            span_y_reg         <= span_y_next;
            span_offset_reg    <= span_offset_next;
            skip_span_reg      <= skip_span_next;
            seq_reg            <= seq_next;
            step_reg           <= step_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // datapath and payload
    always_ff @(posedge aclk) begin
        d2_reg        <= d2_next;
        tsq_reg       <= tsq_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        r_reg         <= r_next;
        g_reg         <= g_next;
        b_reg         <= b_next;
        pend_done_reg <= pend_done_next;
        m_we_reg      <= m_we_next;
        m_x_reg       <= m_x_next;
        m_y_reg       <= m_y_next;
        m_r_reg       <= m_r_next;
        m_g_reg       <= m_g_next;
        m_b_reg       <= m_b_next;
        m_a_reg       <= m_a_next;
        m_done_reg    <= m_done_next;
    end

    // output slot is always free by the time a computed pixel is ready
    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == ssdck_pkg::SEQ_OUT |-> !m_valid_reg)
        else $error("computed pixel finds output register occupied");

    // divide remainder stays below the threshold, so the quotient fits a byte
    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == ssdck_pkg::SEQ_DIV |-> rem_reg < {10'd0, key_threshold_reg})
        else $error("divide remainder out of range");

    // a written pixel lies inside the frame width
    a_write_clipped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_we_reg |-> m_x_reg < frame_width_reg)
        else $error("pixel write outside the frame");

    // a request without a write carries zero payload and ends the frame
    a_nowrite_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_we_reg |-> m_done_reg && m_a_reg == 8'd0 && m_x_reg == 16'd0)
        else $error("result without write is malformed");

endmodule

`default_nettype wire
